>>> hw/rtl/ray_sphere_intersect_assert.svh
// Assertion macros for the ray / sphere intersection block
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RSI_CHECK_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSI_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rsi_pkg.sv
package rsi_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int DIR_WIDTH           = 18;
   localparam int R2_WIDTH            = 31;
   localparam int FRAC_BITS           = 16;
   localparam int DIST_OFFSET         = 66;   // 0.001 in Q16.16

   // projection B, Q16.16
   function automatic int b_width(input int cw);
      return cw + 1 + DIR_WIDTH + 2 - FRAC_BITS;
   endfunction

   // discriminant C, Q32.32, signed
   function automatic int c_width(input int cw);
      int bb;
      bb = 2 * b_width(cw);
      return ((bb > R2_WIDTH + FRAC_BITS) ? bb : R2_WIDTH + FRAC_BITS) + 2;
   endfunction

   function automatic int root_width(input int cw);
      return c_width(cw) / 2;
   endfunction

   // {c_negative, proj, dir, origin}
   function automatic int side_width(input int cw);
      return 1 + b_width(cw) + 3 * DIR_WIDTH + 3 * cw;
   endfunction

endpackage

>>> hw/rtl/rsi_if.sv
interface rsi_req_if #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
);
   logic                                 valid;
   logic                                 ready;
   logic signed [COORD_WIDTH-1:0]        origin_x;
   logic signed [COORD_WIDTH-1:0]        origin_y;
   logic signed [COORD_WIDTH-1:0]        origin_z;
   logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_x;
   logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_y;
   logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_z;
   logic signed [COORD_WIDTH-1:0]        center_x;
   logic signed [COORD_WIDTH-1:0]        center_y;
   logic signed [COORD_WIDTH-1:0]        center_z;
   logic [rsi_pkg::R2_WIDTH-1:0]         radius_squared;

   modport source (
      output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
             center_x, center_y, center_z, radius_squared,
      input  ready
   );
   modport sink (
      input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
             center_x, center_y, center_z, radius_squared,
      output ready
   );
endinterface

interface rsi_rsp_if #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] hit_distance;
   logic signed [COORD_WIDTH-1:0] hit_x;
   logic signed [COORD_WIDTH-1:0] hit_y;
   logic signed [COORD_WIDTH-1:0] hit_z;

   modport source (
      output valid, hit, hit_distance, hit_x, hit_y, hit_z,
      input  ready
   );
   modport sink (
      input  valid, hit, hit_distance, hit_x, hit_y, hit_z,
      output ready
   );
endinterface

>>> hw/rtl/rsi_geom.sv
module rsi_geom #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  logic [3*COORD_WIDTH-1:0]                   origin,
   input  logic [3*COORD_WIDTH-1:0]                   center,
   input  logic [3*rsi_pkg::DIR_WIDTH-1:0]            dir,
   input  logic [rsi_pkg::R2_WIDTH-1:0]               radius_squared,
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic [rsi_pkg::c_width(COORD_WIDTH)-2:0]   radicand,
   output logic                                       c_negative,
   output logic signed [rsi_pkg::b_width(COORD_WIDTH)-1:0] proj,
   output logic [3*COORD_WIDTH-1:0]                   origin_out,
   output logic [3*rsi_pkg::DIR_WIDTH-1:0]            dir_out
);

   localparam int W    = COORD_WIDTH;
   localparam int DIRW = rsi_pkg::DIR_WIDTH;
   localparam int FRAC = rsi_pkg::FRAC_BITS;
   localparam int R2W  = rsi_pkg::R2_WIDTH;
   localparam int DW   = W + 1;
   localparam int SL   = (DW + 1) / 2;
   localparam int SH   = DW - SL;
   localparam int PW   = DW + DIRW;
   localparam int AW   = PW + 2;
   localparam int BW   = rsi_pkg::b_width(W);
   localparam int BL   = (BW + 1) / 2;
   localparam int BH   = BW - BL;
   localparam int BBW  = 2 * BW;
   localparam int DDW  = 2 * DW + 2;
   localparam int CW   = rsi_pkg::c_width(W);
   localparam int SDW  = 3 * W + 3 * DIRW;
   localparam int NST  = 7;

   logic [NST-1:0] v_ff;
   logic [NST:0]   en;

   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NST-1];

   // stage 1: d = centre - origin
   logic signed [DW-1:0] s1_d_in [3];
   logic signed [DW-1:0] s1_d_ff [3];
   logic [DW-1:0]        s1_dabs_in [3];
   logic [DW-1:0]        s1_dabs_ff [3];
   logic [R2W-1:0]       s1_r2_ff;
   logic [SDW-1:0]       s1_side_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s1_d_in[a] = DW'($signed(center[a*W +: W])) - DW'($signed(origin[a*W +: W]));
         s1_dabs_in[a] = s1_d_in[a][DW-1] ? $unsigned(-s1_d_in[a]) : $unsigned(s1_d_in[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_d_ff    <= s1_d_in;
         s1_dabs_ff <= s1_dabs_in;
         s1_r2_ff   <= radius_squared;
         s1_side_ff <= {origin, dir};
      end
   end

   // stage 2: dot terms and split squares
   logic signed [PW-1:0]    s2_dot_in [3];
   logic signed [PW-1:0]    s2_dot_ff [3];
   logic [2*SH-1:0]         s2_hh_in [3];
   logic [2*SH-1:0]         s2_hh_ff [3];
   logic [SH+SL-1:0]        s2_hl_in [3];
   logic [SH+SL-1:0]        s2_hl_ff [3];
   logic [2*SL-1:0]         s2_ll_in [3];
   logic [2*SL-1:0]         s2_ll_ff [3];
   logic [R2W-1:0]          s2_r2_ff;
   logic [SDW-1:0]          s2_side_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s2_dot_in[a] = PW'(s1_d_ff[a]) * PW'($signed(s1_side_ff[a*DIRW +: DIRW]));
         s2_hh_in[a]  = (2*SH)'(s1_dabs_ff[a][DW-1:SL]) * (2*SH)'(s1_dabs_ff[a][DW-1:SL]);
         s2_hl_in[a]  = (SH+SL)'(s1_dabs_ff[a][DW-1:SL]) * (SH+SL)'(s1_dabs_ff[a][SL-1:0]);
         s2_ll_in[a]  = (2*SL)'(s1_dabs_ff[a][SL-1:0]) * (2*SL)'(s1_dabs_ff[a][SL-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_dot_ff  <= s2_dot_in;
         s2_hh_ff   <= s2_hh_in;
         s2_hl_ff   <= s2_hl_in;
         s2_ll_ff   <= s2_ll_in;
         s2_r2_ff   <= s1_r2_ff;
         s2_side_ff <= s1_side_ff;
      end
   end

   // stage 3: dot sum, per-axis squares
   logic signed [AW-1:0] s3_acc_in;
   logic signed [AW-1:0] s3_acc_ff;
   logic [2*DW-1:0]      s3_sq_in [3];
   logic [2*DW-1:0]      s3_sq_ff [3];
   logic [R2W-1:0]       s3_r2_ff;
   logic [SDW-1:0]       s3_side_ff;

   always_comb begin
      s3_acc_in = AW'(s2_dot_ff[0]) + AW'(s2_dot_ff[1]) + AW'(s2_dot_ff[2]);
      for (int a = 0; a < 3; a++) begin
         s3_sq_in[a] = ((2*DW)'(s2_hh_ff[a]) << (2*SL))
                     + ((2*DW)'(s2_hl_ff[a]) << (SL + 1))
                     + (2*DW)'(s2_ll_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_acc_ff  <= s3_acc_in;
         s3_sq_ff   <= s3_sq_in;
         s3_r2_ff   <= s2_r2_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // stage 4: B = floor(acc / 2^16), |d|^2
   logic signed [BW-1:0] s4_b_in;
   logic signed [BW-1:0] s4_b_ff;
   logic [BW-1:0]        s4_babs_in;
   logic [BW-1:0]        s4_babs_ff;
   logic [DDW-1:0]       s4_dd_in;
   logic [DDW-1:0]       s4_dd_ff;
   logic [R2W-1:0]       s4_r2_ff;
   logic [SDW-1:0]       s4_side_ff;

   always_comb begin
      s4_b_in    = $signed(s3_acc_ff[AW-1:FRAC]);
      s4_babs_in = s4_b_in[BW-1] ? $unsigned(-s4_b_in) : $unsigned(s4_b_in);
      s4_dd_in   = DDW'(s3_sq_ff[0]) + DDW'(s3_sq_ff[1]) + DDW'(s3_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_b_ff    <= s4_b_in;
         s4_babs_ff <= s4_babs_in;
         s4_dd_ff   <= s4_dd_in;
         s4_r2_ff   <= s3_r2_ff;
         s4_side_ff <= s3_side_ff;
      end
   end

   // stage 5: split B*B
   logic [2*BH-1:0]      s5_hh_in;
   logic [2*BH-1:0]      s5_hh_ff;
   logic [BH+BL-1:0]     s5_hl_in;
   logic [BH+BL-1:0]     s5_hl_ff;
   logic [2*BL-1:0]      s5_ll_in;
   logic [2*BL-1:0]      s5_ll_ff;
   logic signed [BW-1:0] s5_b_ff;
   logic [DDW-1:0]       s5_dd_ff;
   logic [R2W-1:0]       s5_r2_ff;
   logic [SDW-1:0]       s5_side_ff;

   always_comb begin
      s5_hh_in = (2*BH)'(s4_babs_ff[BW-1:BL]) * (2*BH)'(s4_babs_ff[BW-1:BL]);
      s5_hl_in = (BH+BL)'(s4_babs_ff[BW-1:BL]) * (BH+BL)'(s4_babs_ff[BL-1:0]);
      s5_ll_in = (2*BL)'(s4_babs_ff[BL-1:0]) * (2*BL)'(s4_babs_ff[BL-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_hh_ff   <= s5_hh_in;
         s5_hl_ff   <= s5_hl_in;
         s5_ll_ff   <= s5_ll_in;
         s5_b_ff    <= s4_b_ff;
         s5_dd_ff   <= s4_dd_ff;
         s5_r2_ff   <= s4_r2_ff;
         s5_side_ff <= s4_side_ff;
      end
   end

   // stage 6: B*B and r^2 - |d|^2
   logic [BBW-1:0]       s6_bb_in;
   logic [BBW-1:0]       s6_bb_ff;
   logic signed [CW-1:0] s6_rmd_in;
   logic signed [CW-1:0] s6_rmd_ff;
   logic signed [BW-1:0] s6_b_ff;
   logic [SDW-1:0]       s6_side_ff;

   always_comb begin
      s6_bb_in  = (BBW'(s5_hh_ff) << (2*BL)) + (BBW'(s5_hl_ff) << (BL + 1)) + BBW'(s5_ll_ff);
      s6_rmd_in = $signed(CW'({s5_r2_ff, {FRAC{1'b0}}})) - $signed(CW'(s5_dd_ff));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_bb_ff   <= s6_bb_in;
         s6_rmd_ff  <= s6_rmd_in;
         s6_b_ff    <= s5_b_ff;
         s6_side_ff <= s5_side_ff;
      end
   end

   // stage 7: discriminant C
   logic signed [CW-1:0] s7_c_in;
   logic                 s7_cneg_in;
   logic [CW-2:0]        s7_rad_in;
   logic                 s7_cneg_ff;
   logic [CW-2:0]        s7_rad_ff;
   logic signed [BW-1:0] s7_b_ff;
   logic [SDW-1:0]       s7_side_ff;

   always_comb begin
      s7_c_in    = $signed(CW'(s6_bb_ff)) + s6_rmd_ff;
      s7_cneg_in = s7_c_in[CW-1];
      s7_rad_in  = s7_cneg_in ? '0 : s7_c_in[CW-2:0];
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_cneg_ff <= s7_cneg_in;
         s7_rad_ff  <= s7_rad_in;
         s7_b_ff    <= s6_b_ff;
         s7_side_ff <= s6_side_ff;
      end
   end

   assign radicand   = s7_rad_ff;
   assign c_negative = s7_cneg_ff;
   assign proj       = s7_b_ff;
   assign origin_out = s7_side_ff[SDW-1:3*DIRW];
   assign dir_out    = s7_side_ff[3*DIRW-1:0];

endmodule

>>> hw/rtl/rsi_sqrt.sv
module rsi_sqrt #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  logic [rsi_pkg::c_width(COORD_WIDTH)-2:0]      radicand,
   input  logic [rsi_pkg::side_width(COORD_WIDTH)-1:0]   side_in,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output logic [rsi_pkg::root_width(COORD_WIDTH)-1:0]   root,
   output logic [rsi_pkg::side_width(COORD_WIDTH)-1:0]   side_out
);

   localparam int RW   = rsi_pkg::root_width(COORD_WIDTH);
   localparam int RADW = 2 * RW;
   localparam int SW   = rsi_pkg::side_width(COORD_WIDTH);

   // one root bit per stage, restoring
   logic [RW-1:0]   v_ff;
   logic [RW:0]     en;
   logic [RW+1:0]   rem_in  [RW];
   logic [RW+1:0]   rem_ff  [RW];
   logic [RW-1:0]   q_in    [RW];
   logic [RW-1:0]   q_ff    [RW];
   logic [RADW-1:0] rad_in  [RW];
   logic [RADW-1:0] rad_ff  [RW];
   logic [SW-1:0]   side_ff [RW];

   always_comb begin
      en[RW] = out_ready;
      for (int k = RW - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < RW; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW-1:0]   rem_prev;
      logic [RW-1:0]   q_prev;
      logic [RADW-1:0] rad_prev;
      logic [SW-1:0]   side_prev;
      logic [RW+1:0]   rem_sh;
      logic [RW+1:0]   trial;
      logic            take;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign q_prev    = '0;
         assign rad_prev  = RADW'(radicand);
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1][RW-1:0];
         assign q_prev    = q_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign rem_sh    = {rem_prev, rad_prev[RADW-1 -: 2]};
      assign trial     = {q_prev, 2'b01};
      assign take      = rem_sh >= trial;
      assign rem_in[k] = take ? rem_sh - trial : rem_sh;
      assign q_in[k]   = {q_prev[RW-2:0], take};
      assign rad_in[k] = rad_prev << 2;

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_prev;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[RW-1];
   assign root      = q_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

>>> hw/rtl/rsi_hit.sv
module rsi_hit #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   output logic                                            in_ready,
   input  logic [rsi_pkg::root_width(COORD_WIDTH)-1:0]     root,
   input  logic                                            c_negative,
   input  logic signed [rsi_pkg::b_width(COORD_WIDTH)-1:0] proj,
   input  logic [3*COORD_WIDTH-1:0]                        origin,
   input  logic [3*rsi_pkg::DIR_WIDTH-1:0]                 dir,
   output logic                                            out_valid,
   input  logic                                            out_ready,
   output logic                                            hit,
   output logic signed [COORD_WIDTH-1:0]                   hit_distance,
   output logic signed [COORD_WIDTH-1:0]                   hit_x,
   output logic signed [COORD_WIDTH-1:0]                   hit_y,
   output logic signed [COORD_WIDTH-1:0]                   hit_z
);

   localparam int W    = COORD_WIDTH;
   localparam int DIRW = rsi_pkg::DIR_WIDTH;
   localparam int FRAC = rsi_pkg::FRAC_BITS;
   localparam int BW   = rsi_pkg::b_width(W);
   localparam int RW   = rsi_pkg::root_width(W);
   localparam int EW   = ((BW > RW + 1) ? BW : RW + 1) + 1;
   localparam int DSW  = EW + 1;
   localparam int HPW  = DIRW + DSW;
   localparam int PTW  = HPW - FRAC + 1;
   localparam int NST  = 3;

   function automatic logic [W-1:0] sat_coord(input logic signed [PTW-1:0] x);
      logic [PTW-W:0] upper;
      upper = x[PTW-1:W-1];
      if (&upper || !(|upper)) begin
         sat_coord = x[W-1:0];
      end else if (x[PTW-1]) begin
         sat_coord = {1'b1, {(W-1){1'b0}}};
      end else begin
         sat_coord = {1'b0, {(W-1){1'b1}}};
      end
   endfunction

   logic [NST-1:0] v_ff;
   logic [NST:0]   en;

   always_comb begin
      en[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NST-1];

   // stage 1: roots, pick, offset
   logic signed [EW-1:0]  h1_e_in;
   logic signed [EW-1:0]  h1_f_in;
   logic signed [DSW-1:0] h1_dist_in;
   logic                  h1_hit_in;
   logic signed [DSW-1:0] h1_dist_ff;
   logic                  h1_hit_ff;
   logic [3*W-1:0]        h1_origin_ff;
   logic [3*DIRW-1:0]     h1_dir_ff;

   always_comb begin
      h1_e_in    = EW'(proj) + $signed(EW'(root));
      h1_f_in    = EW'(proj) - $signed(EW'(root));
      h1_hit_in  = !c_negative && !h1_e_in[EW-1];
      h1_dist_in = ((h1_f_in > 0) ? DSW'(h1_f_in) : DSW'(h1_e_in))
                 - DSW'(rsi_pkg::DIST_OFFSET);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         h1_dist_ff   <= h1_dist_in;
         h1_hit_ff    <= h1_hit_in;
         h1_origin_ff <= origin;
         h1_dir_ff    <= dir;
      end
   end

   // stage 2: dir * dist
   logic signed [HPW-1:0] h2_prod_in [3];
   logic signed [HPW-1:0] h2_prod_ff [3];
   logic signed [DSW-1:0] h2_dist_ff;
   logic                  h2_hit_ff;
   logic [3*W-1:0]        h2_origin_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         h2_prod_in[a] = HPW'($signed(h1_dir_ff[a*DIRW +: DIRW])) * HPW'(h1_dist_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         h2_prod_ff   <= h2_prod_in;
         h2_dist_ff   <= h1_dist_ff;
         h2_hit_ff    <= h1_hit_ff;
         h2_origin_ff <= h1_origin_ff;
      end
   end

   // stage 3: point, saturate, zero on miss
   logic signed [PTW-1:0] h3_pt [3];
   logic [W-1:0]          h3_coord_in [3];
   logic [W-1:0]          h3_coord_ff [3];
   logic [W-1:0]          h3_dist_in;
   logic [W-1:0]          h3_dist_ff;
   logic                  h3_hit_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         h3_pt[a] = PTW'($signed(h2_prod_ff[a][HPW-1:FRAC]))
                  + PTW'($signed(h2_origin_ff[a*W +: W]));
         h3_coord_in[a] = h2_hit_ff ? sat_coord(h3_pt[a]) : '0;
      end
      h3_dist_in = h2_hit_ff ? sat_coord(PTW'(h2_dist_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         h3_coord_ff <= h3_coord_in;
         h3_dist_ff  <= h3_dist_in;
         h3_hit_ff   <= h2_hit_ff;
      end
   end

   assign hit          = h3_hit_ff;
   assign hit_distance = $signed(h3_dist_ff);
   assign hit_x        = $signed(h3_coord_ff[0]);
   assign hit_y        = $signed(h3_coord_ff[1]);
   assign hit_z        = $signed(h3_coord_ff[2]);

endmodule

>>> hw/rtl/ray_sphere_intersect.sv
// channel   dir  port      handshake      payload
// request   in   req_chan  valid / ready  origin, dir, center, radius_squared
// response  out  rsp_chan  valid / ready  hit, hit_distance, hit_x/y/z
//
// One item per cycle sustained while the response side is ready; every stage holds one item.
// The square-root pipeline works out R root bits, 38 at COORD_WIDTH 32.
// Synchronous reset clears the stage valid bits only.
// Each stage loads when it is empty or the stage after it moves, so a stalled
// response holds the pipe and gaps close up behind it.

`include "ray_sphere_intersect_assert.svh"

module ray_sphere_intersect #(
   parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   rsi_req_if.sink   req_chan,
   rsi_rsp_if.source rsp_chan
);

   localparam int W    = COORD_WIDTH;
   localparam int DIRW = rsi_pkg::DIR_WIDTH;
   localparam int BW   = rsi_pkg::b_width(W);
   localparam int CW   = rsi_pkg::c_width(W);
   localparam int RW   = rsi_pkg::root_width(W);
   localparam int SW   = rsi_pkg::side_width(W);

   logic                 g_valid;
   logic                 g_ready;
   logic [CW-2:0]        g_radicand;
   logic                 g_cneg;
   logic signed [BW-1:0] g_proj;
   logic [3*W-1:0]       g_origin;
   logic [3*DIRW-1:0]    g_dir;

   logic                 s_valid;
   logic                 s_ready;
   logic [RW-1:0]        s_root;
   logic [SW-1:0]        s_side_in;
   logic [SW-1:0]        s_side_out;

   rsi_geom #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_geom (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .origin         ({req_chan.origin_z, req_chan.origin_y, req_chan.origin_x}),
      .center         ({req_chan.center_z, req_chan.center_y, req_chan.center_x}),
      .dir            ({req_chan.dir_z, req_chan.dir_y, req_chan.dir_x}),
      .radius_squared (req_chan.radius_squared),
      .out_valid      (g_valid),
      .out_ready      (g_ready),
      .radicand       (g_radicand),
      .c_negative     (g_cneg),
      .proj           (g_proj),
      .origin_out     (g_origin),
      .dir_out        (g_dir)
   );

   assign s_side_in = {g_cneg, g_proj, g_dir, g_origin};

   rsi_sqrt #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (g_valid),
      .in_ready  (g_ready),
      .radicand  (g_radicand),
      .side_in   (s_side_in),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .root      (s_root),
      .side_out  (s_side_out)
   );

   rsi_hit #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_hit (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s_valid),
      .in_ready     (s_ready),
      .root         (s_root),
      .c_negative   (s_side_out[SW-1]),
      .proj         ($signed(s_side_out[3*W+3*DIRW +: BW])),
      .origin       (s_side_out[3*W-1:0]),
      .dir          (s_side_out[3*W +: 3*DIRW]),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .hit          (rsp_chan.hit),
      .hit_distance (rsp_chan.hit_distance),
      .hit_x        (rsp_chan.hit_x),
      .hit_y        (rsp_chan.hit_y),
      .hit_z        (rsp_chan.hit_z)
   );

   `RSI_CHECK_IMPL(a_miss_zero, clock, reset, rsp_chan.valid && !rsp_chan.hit, (rsp_chan.hit_distance == '0) && (rsp_chan.hit_x == '0) && (rsp_chan.hit_y == '0) && (rsp_chan.hit_z == '0), "miss item carries nonzero fields")
   `RSI_CHECK_IMPL(a_hit_dist_floor, clock, reset, rsp_chan.valid && rsp_chan.hit, $signed(rsp_chan.hit_distance) >= -rsi_pkg::DIST_OFFSET, "hit distance below the offset floor")
   `RSI_CHECK_IMPL(a_ready_chain, clock, reset, rsp_chan.ready, req_chan.ready, "pipe stalled while response side is ready")

endmodule

>>> dv/ray_sphere_intersect_tb.sv
`timescale 1ns / 1ps

module ray_sphere_intersect_tb;

   localparam int CW   = rsi_pkg::COORD_WIDTH_DEFAULT;
   localparam int DW   = rsi_pkg::DIR_WIDTH;
   localparam int R2W  = rsi_pkg::R2_WIDTH;
   localparam int FRAC = rsi_pkg::FRAC_BITS;

   localparam longint UNIT      = 65536;
   localparam longint MAX_COORD = 64'sh7FFF_FFFF;
   localparam longint MIN_COORD = -64'sh8000_0000;
   localparam longint MAX_R2    = 64'sh7FFF_FFFF;

   localparam int RANDOM_RAYS  = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 64;
   localparam int QUIET_LIMIT  = 2000;

   typedef struct packed {
      logic [2:0][CW-1:0] origin;
      logic [2:0][DW-1:0] dir;
      logic [2:0][CW-1:0] center;
      logic [R2W-1:0]     r2;
   } ray_type;

   typedef struct packed {
      logic               hit;
      logic [CW-1:0]      distance;
      logic [2:0][CW-1:0] point;
   } hit_type;

   typedef struct packed {
      ray_type ray;
      logic    known;
      hit_type result;
   } stim_row_type;

   localparam hit_type NO_HIT = '0;

   logic clock = 1'b0;
   logic reset;

   rsi_req_if #(.COORD_WIDTH(CW)) req ();
   rsi_rsp_if #(.COORD_WIDTH(CW)) rsp ();

   ray_sphere_intersect #(.COORD_WIDTH(CW)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always #5 clock = ~clock;

   hit_type      pending_hits[$];
   stim_row_type directed_rows[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int error_count   = 0;
   int rays_sent     = 0;
   int hits_seen     = 0;
   int misses_seen   = 0;

   function automatic ray_type mk_ray(input longint ox, oy, oz, dx, dy, dz, cx, cy, cz, rr);
      ray_type r;
      r.origin[0] = CW'(ox);
      r.origin[1] = CW'(oy);
      r.origin[2] = CW'(oz);
      r.dir[0]    = DW'(dx);
      r.dir[1]    = DW'(dy);
      r.dir[2]    = DW'(dz);
      r.center[0] = CW'(cx);
      r.center[1] = CW'(cy);
      r.center[2] = CW'(cz);
      r.r2        = R2W'(rr);
      return r;
   endfunction

   function automatic hit_type mk_hit(input longint span, px, py, pz);
      hit_type h;
      h.hit      = 1'b1;
      h.distance = CW'(span);
      h.point[0] = CW'(px);
      h.point[1] = CW'(py);
      h.point[2] = CW'(pz);
      return h;
   endfunction

   task automatic add_row(input ray_type r, input logic known, input hit_type h);
      stim_row_type row;
      row.ray    = r;
      row.known  = known;
      row.result = h;
      directed_rows.push_back(row);
   endtask

   function automatic logic [CW-1:0] clamp(input logic signed [127:0] v);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (CW - 1)) - 128'sd1;
      lo_lim = -hi_lim - 128'sd1;
      if (v > hi_lim) begin
         return hi_lim[CW-1:0];
      end
      if (v < lo_lim) begin
         return lo_lim[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   // full-width fixed point: B = floor(d.D / 2^16), C = B*B - d.d + r2*2^16
   function automatic hit_type trace_ray(input ray_type r);
      hit_type             h;
      logic signed [127:0] org [3];
      logic signed [127:0] dv [3];
      logic signed [127:0] dlt [3];
      logic signed [127:0] proj_acc, len_sq, r2w, b, disc, rt, e, f, span, p;
      logic [127:0]        root, cand;
      h = NO_HIT;
      proj_acc = 0;
      len_sq = 0;
      for (int i = 0; i < 3; i++) begin
         org[i] = $signed(r.origin[i]);
         dv[i]  = $signed(r.dir[i]);
         dlt[i] = $signed(r.center[i]);
         dlt[i] = dlt[i] - org[i];
         proj_acc = proj_acc + dlt[i] * dv[i];
         len_sq = len_sq + dlt[i] * dlt[i];
      end
      r2w = r.r2;
      b = proj_acc >>> FRAC;
      disc = b * b - len_sq + (r2w <<< FRAC);
      if (disc < 0) begin
         return h;
      end
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = root | (128'd1 << i);
         if (cand * cand <= disc) begin
            root = cand;
         end
      end
      rt = root;
      e = b + rt;
      if (e < 0) begin
         return h;
      end
      f = b - rt;
      span = ((f > 0) ? f : e) - rsi_pkg::DIST_OFFSET;
      h.hit = 1'b1;
      h.distance = clamp(span);
      for (int i = 0; i < 3; i++) begin
         p = ((dv[i] * span) >>> FRAC) + org[i];
         h.point[i] = clamp(p);
      end
      return h;
   endfunction

   // mostly rays aimed near a sphere of random size; the rest raw bits or small values
   function automatic ray_type random_ray();
      ray_type     r;
      real         u [3];
      real         mag, t, rad;
      int unsigned pick;
      longint      base, pos;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         for (int i = 0; i < 3; i++) begin
            u[i] = real'($urandom_range(0, 2000000)) / 1.0e6 - 1.0;
         end
         mag = $sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
         if (mag < 1.0e-3) begin
            u[0] = 1.0;
            u[1] = 0.0;
            u[2] = 0.0;
            mag = 1.0;
         end
         t = real'($urandom_range(0, 22000)) / 100.0 - 20.0;
         rad = real'($urandom_range(10, 5000)) / 100.0;
         for (int i = 0; i < 3; i++) begin
            r.dir[i] = DW'($rtoi(u[i] / mag * 65536.0));
            base = longint'($urandom_range(0, 1 << 27)) - (1 << 26);
            r.origin[i] = CW'(base);
            pos = base + longint'($rtoi((u[i] / mag * t
               + (real'($urandom_range(0, 2000)) / 1000.0 - 1.0) * rad * 0.8) * 65536.0));
            r.center[i] = CW'(pos);
         end
         if ($urandom_range(0, 9) == 0) begin
            r.r2 = R2W'($urandom);
         end else begin
            r.r2 = R2W'($rtoi(rad * rad * 65536.0));
         end
      end else if (pick < 85) begin
         for (int i = 0; i < 3; i++) begin
            r.origin[i] = CW'($urandom);
            r.dir[i]    = DW'($urandom);
            r.center[i] = CW'($urandom);
         end
         r.r2 = R2W'($urandom);
      end else begin
         for (int i = 0; i < 3; i++) begin
            r.origin[i] = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            r.dir[i]    = DW'(int'($urandom_range(0, 131072)) - 65536);
            r.center[i] = CW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         end
         r.r2 = R2W'($urandom_range(0, 1 << 22));
      end
      return r;
   endfunction

   task automatic send_ray(input ray_type r, input hit_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid          <= 1'b1;
      req.origin_x       <= r.origin[0];
      req.origin_y       <= r.origin[1];
      req.origin_z       <= r.origin[2];
      req.dir_x          <= r.dir[0];
      req.dir_y          <= r.dir[1];
      req.dir_z          <= r.dir[2];
      req.center_x       <= r.center[0];
      req.center_y       <= r.center[1];
      req.center_z       <= r.center[2];
      req.radius_squared <= r.r2;
      @(posedge clock);
      while (!req.ready) begin
         @(posedge clock);
      end
      pending_hits.push_back(want);
      rays_sent++;
   endtask

   task automatic send_random(input int count);
      ray_type r;
      for (int n = 0; n < count; n++) begin
         r = random_ray();
         send_ray(r, trace_ray(r));
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_hits.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string what, input logic [CW-1:0] want_v,
                              input logic [CW-1:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      end
   endtask

   // result side: checks, random stalls and the long hold-off
   initial begin
      hit_type oldest;
      int      hold_seen;
      int      hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            if (pending_hits.size() == 0) begin
               error_count++;
               $display("%0t: unexpected item, expected none, actual hit=%b dist=%h",
                        $time, rsp.hit, rsp.hit_distance);
            end else begin
               oldest = pending_hits.pop_front();
               if (oldest.hit) begin
                  hits_seen++;
               end else begin
                  misses_seen++;
               end
               check_field("hit", CW'(oldest.hit), CW'(rsp.hit));
               check_field("hit_distance", oldest.distance, rsp.hit_distance);
               check_field("hit_x", oldest.point[0], rsp.hit_x);
               check_field("hit_y", oldest.point[1], rsp.hit_y);
               check_field("hit_z", oldest.point[2], rsp.hit_z);
            end
         end
         if (reset) begin
            rsp.ready <= 1'b0;
         end else begin
            if (hold_seen != hold_requests) begin
               hold_seen = hold_requests;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
               $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                        $time, QUIET_LIMIT, pending_hits.size());
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   initial begin
      reset              <= 1'b1;
      req.valid          <= 1'b0;
      req.origin_x       <= '0;
      req.origin_y       <= '0;
      req.origin_z       <= '0;
      req.dir_x          <= '0;
      req.dir_y          <= '0;
      req.dir_z          <= '0;
      req.center_x       <= '0;
      req.center_y       <= '0;
      req.center_z       <= '0;
      req.radius_squared <= '0;

      // straight hit, sphere behind, clean miss
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, 10 * UNIT, 0, 0, UNIT), 1'b1,
              mk_hit(589758, 589758, 0, 0));
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, -10 * UNIT, 0, 0, UNIT), 1'b1, NO_HIT);
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, 10 * UNIT, 5 * UNIT, 0, UNIT), 1'b1, NO_HIT);
      // origin inside the sphere: far root
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, 0, 0, 0, UNIT), 1'b1,
              mk_hit(65470, 65470, 0, 0));
      // near root exactly zero falls back to the far root
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, UNIT, 0, 0, UNIT), 1'b1,
              mk_hit(131006, 131006, 0, 0));
      // tangent, discriminant zero, then straight hits along -x, +y and +z
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, 10 * UNIT, UNIT, 0, UNIT), 1'b1,
              mk_hit(655294, 655294, 0, 0));
      add_row(mk_ray(0, 0, 0, -UNIT, 0, 0, -10 * UNIT, 0, 0, UNIT), 1'b1,
              mk_hit(589758, -589758, 0, 0));
      add_row(mk_ray(0, 0, 0, 0, UNIT, 0, 0, 10 * UNIT, 0, UNIT), 1'b1,
              mk_hit(589758, 0, 589758, 0));
      add_row(mk_ray(0, 0, 0, 0, 0, UNIT, 0, 0, 10 * UNIT, UNIT), 1'b1,
              mk_hit(589758, 0, 0, 589758));
      // zero direction
      add_row(mk_ray(0, 0, 0, 0, 0, 0, 3 * UNIT, 0, 0, UNIT), 1'b1, NO_HIT);
      add_row(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, UNIT), 1'b1, mk_hit(65470, 0, 0, 0));
      // zero radius on the ray
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, 10 * UNIT, 0, 0, 0), 1'b1,
              mk_hit(655294, 655294, 0, 0));
      // everything zero: negative distance
      add_row(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, mk_hit(-66, 0, 0, 0));
      add_row(mk_ray(MIN_COORD, MIN_COORD, MIN_COORD, 0, 0, 0,
                     MIN_COORD, MIN_COORD, MIN_COORD, 0), 1'b1,
              mk_hit(-66, MIN_COORD, MIN_COORD, MIN_COORD));
      // extremes and saturation
      add_row(mk_ray(0, 0, 0, UNIT, 0, 0, 0, 0, 0, MAX_R2), 1'b0, NO_HIT);
      add_row(mk_ray(MAX_COORD, MAX_COORD, MAX_COORD, UNIT, 0, 0,
                     MAX_COORD, MAX_COORD, MAX_COORD, MAX_R2), 1'b0, NO_HIT);
      add_row(mk_ray(MIN_COORD, 0, 0, UNIT, 0, 0, MAX_COORD, 0, 0, UNIT), 1'b0, NO_HIT);
      add_row(mk_ray(MAX_COORD, 0, 0, -UNIT, 0, 0, MIN_COORD, 0, 0, UNIT), 1'b0, NO_HIT);
      add_row(mk_ray(MIN_COORD, MAX_COORD, MIN_COORD, UNIT, 0, 0,
                     MAX_COORD, MAX_COORD, MIN_COORD, MAX_R2), 1'b0, NO_HIT);
      // direction at the raw field limits, non-unit
      add_row(mk_ray(UNIT, 2 * UNIT, -UNIT, -131072, -131072, -131072,
                     -5 * UNIT, -5 * UNIT, -5 * UNIT, 100 * UNIT), 1'b0, NO_HIT);
      add_row(mk_ray(-UNIT, 0, UNIT, 131071, 131071, 131071,
                     5 * UNIT, 5 * UNIT, 5 * UNIT, 100 * UNIT), 1'b0, NO_HIT);
      add_row(mk_ray(UNIT, -2 * UNIT, 3 * UNIT, 37837, 37837, 37837,
                     10 * UNIT, 10 * UNIT, 10 * UNIT, 4 * UNIT), 1'b0, NO_HIT);
      add_row(mk_ray(3 * UNIT, 0, 0, -37837, 37837, -37837,
                     -7 * UNIT + 123, 9 * UNIT - 77, -11 * UNIT, 9 * UNIT + 4321), 1'b0, NO_HIT);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 14;
      recv_idle_pct = 71;
      foreach (directed_rows[i]) begin
         send_ray(directed_rows[i].ray,
                  directed_rows[i].known ? directed_rows[i].result
                                         : trace_ray(directed_rows[i].ray));
      end
      send_random(RANDOM_RAYS / 3);
      drain();

      send_idle_pct = 71;
      recv_idle_pct = 14;
      send_random(RANDOM_RAYS / 3);
      drain();

      // back-to-back, with one long output stall to fill the pipe
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      send_random(RANDOM_RAYS - 2 * (RANDOM_RAYS / 3));
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Traced %0d rays: %0d hits, %0d misses, %0d mismatches", rays_sent,
               hits_seen, misses_seen, error_count);
      $display("Covered field extremes, saturation, tangent and inside cases, three idle mixes");
      if (error_count == 0 && pending_hits.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> ray_sphere_intersect.f
+incdir+hw/rtl
hw/rtl/rsi_pkg.sv
hw/rtl/rsi_if.sv
hw/rtl/rsi_geom.sv
hw/rtl/rsi_sqrt.sv
hw/rtl/rsi_hit.sv
hw/rtl/ray_sphere_intersect.sv
dv/ray_sphere_intersect_tb.sv
